// ----- rtl/kst_pkg.sv -----
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types and constants for the keyed stopwatch table.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam logic [31:0] FreqReset    = 32'd10000000;
  localparam logic [31:0] ElapsedMax   = 32'hFFFF_FFFF;
  localparam logic [9:0]  MsPerSecond  = 10'd1000;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_RUNNING  = 2'd3
  } status_e;

  // Command from the controller to every cell of the row.
  typedef struct packed {
    logic        append;   // store key/start in the first empty cell
    logic        remove;   // drop the oldest matching cell and close the gap
    logic [31:0] key;
    logic [63:0] stamp;
  } cell_cmd_t;

endpackage

// ----- rtl/keyed_stopwatch_table.sv -----
// ----------------------------------------------------------------------------
// keyed_stopwatch_table
// Tick, start and failed stop go from S_EXEC to S_OUT, where the result shows.
// A successful stop goes from S_EXEC through S_DIV, held there by the bit-serial
// divider (74 dividend bits, one per cycle), and then to S_OUT.
// One item in flight: the next item is taken in S_IDLE only after the result
// has left S_OUT.
// Reset clears the counter, the valid bits of the cell row and the fill count.
// ----------------------------------------------------------------------------
module keyed_stopwatch_table
  import kst_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] identifier_i,
  input  logic        check_existing_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] elapsed_ms_o
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e          state_q;
  logic [31:0]     freq_q;
  logic [63:0]     tick_q;
  logic [CntW-1:0] count_q;
  logic [1:0]      op_q;
  logic [31:0]     key_q;
  logic            chk_q;
  logic [1:0]      status_q;
  logic [31:0]     elapsed_q;
  logic [63:0]     delta_q;
  logic            div_start_q;

  cell_cmd_t       cmd;
  logic [TABLE_DEPTH:0]   hit_c, vld_c;
  logic [TABLE_DEPTH-1:0] match_c;
  logic [31:0]     key_c   [TABLE_DEPTH+1];
  logic [63:0]     start_c [TABLE_DEPTH+1];
  logic [63:0]     found_start;
  logic            any_hit;
  logic            div_done;
  logic [31:0]     div_quot;

  // Row of cells; a virtual empty cell terminates the right end.
  assign hit_c[0]                 = 1'b0;
  assign vld_c[TABLE_DEPTH]       = 1'b0;
  assign key_c[TABLE_DEPTH]       = '0;
  assign start_c[TABLE_DEPTH]     = '0;
  assign any_hit                  = hit_c[TABLE_DEPTH];

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic lv;
    if (g == 0) begin : g_first
      assign lv = 1'b1;
    end else begin : g_rest
      assign lv = vld_c[g-1];
    end
    kst_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .left_valid_i (lv),
      .left_hit_i   (hit_c[g]),
      .right_valid_i(vld_c[g+1]),
      .right_key_i  (key_c[g+1]),
      .right_start_i(start_c[g+1]),
      .valid_o      (vld_c[g]),
      .match_o      (match_c[g]),
      .hit_o        (hit_c[g+1]),
      .key_o        (key_c[g]),
      .start_o      (start_c[g])
    );
  end

  // Select the start stamp of the oldest match (first-hit one-hot).
  always_comb begin
    found_start = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (match_c[i] && !hit_c[i]) begin
        found_start = start_c[i];
      end
    end
  end

  // Issue the cell command in the execute state.
  always_comb begin
    cmd        = '0;
    cmd.key    = key_q;
    cmd.stamp  = tick_q;
    if (state_q == S_EXEC) begin
      cmd.append = (op_q == OP_START) && !(chk_q && any_hit)
                   && (count_q < CntW'(TABLE_DEPTH));
      cmd.remove = (op_q == OP_STOP) && any_hit;
    end
  end

  kst_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start_q),
    .delta_i(delta_q),
    .freq_i (freq_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Control: accept, execute, divide, deliver.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      freq_q      <= FreqReset;
      tick_q      <= '0;
      count_q     <= '0;
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      if (cfg_we_i) begin
        freq_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_OUT;
          case (op_q)
            OP_TICK: tick_q <= tick_q + 64'd1;
            OP_START: begin
              if (cmd.append) begin
                count_q <= count_q + 1'b1;
              end
            end
            OP_STOP: begin
              if (cmd.remove) begin
                count_q     <= count_q - 1'b1;
                div_start_q <= 1'b1;
                state_q     <= S_DIV;
              end
            end
            default: ;
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Item payload and result.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      op_q  <= op_i;
      key_q <= identifier_i;
      chk_q <= check_existing_i;
    end
    if (state_q == S_EXEC) begin
      status_q  <= ST_DONE;
      elapsed_q <= '0;
      delta_q   <= tick_q - found_start;
      if (op_q == OP_START) begin
        if (chk_q && any_hit) begin
          status_q <= ST_RUNNING;
        end else if (!cmd.append) begin
          status_q <= ST_FULL;
        end
      end else if (op_q == OP_STOP && !any_hit) begin
        status_q  <= ST_NOTFOUND;
        elapsed_q <= ElapsedMax;
      end
    end
    if (state_q == S_DIV && div_done) begin
      elapsed_q <= div_quot;
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = (state_q == S_OUT);
  assign status_o     = status_q;
  assign elapsed_ms_o = elapsed_q;

endmodule

// ----- rtl/kst_cell.sv -----
// ----------------------------------------------------------------------------
// kst_cell
// One table entry. Compares its key, takes a new entry when it is the
// first empty cell, and pulls its right neighbor in on a removal.
// ----------------------------------------------------------------------------
module kst_cell
  import kst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cell_cmd_t   cmd_i,
  input  logic        left_valid_i,   // previous cell occupied
  input  logic        left_hit_i,     // a cell to the left matched
  input  logic        right_valid_i,
  input  logic [31:0] right_key_i,
  input  logic [63:0] right_start_i,
  output logic        valid_o,
  output logic        match_o,        // this cell holds the key
  output logic        hit_o,          // this cell or one to the left matched
  output logic [31:0] key_o,
  output logic [63:0] start_o
);

  logic        valid_q, valid_d;
  logic [31:0] key_q, key_d;
  logic [63:0] start_q, start_d;
  logic        shift;

  assign match_o = valid_q && (key_q == cmd_i.key);
  assign hit_o   = left_hit_i || match_o;
  assign shift   = cmd_i.remove && hit_o;

  // Append, shift down or hold.
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    start_d = start_q;
    if (cmd_i.append && !valid_q && left_valid_i) begin
      valid_d = 1'b1;
      key_d   = cmd_i.key;
      start_d = cmd_i.stamp;
    end else if (shift) begin
      valid_d = right_valid_i;
      key_d   = right_key_i;
      start_d = right_start_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    start_q <= start_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign start_o = start_q;

endmodule

// ----- rtl/kst_divider.sv -----
// ----------------------------------------------------------------------------
// kst_divider
// Restoring divider, one quotient bit per cycle: q = (delta*1000) / freq,
// saturated to 32 bits. Dividend is 74 bits wide.
// ----------------------------------------------------------------------------
module kst_divider
  import kst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] delta_i,
  input  logic [31:0] freq_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  localparam int unsigned DivW = 74;
  localparam int unsigned CntW = 7;

  logic [DivW-1:0] num_q;
  logic [DivW-1:0] quo_q;
  logic [32:0]     rem_q;
  logic [31:0]     div_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [32:0]     trial;
  logic            take;

  // Shift in the next dividend bit and try to subtract.
  assign trial = {rem_q[31:0], num_q[DivW-1]};
  assign take  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= DivW'(delta_i) * DivW'(MsPerSecond);
      quo_q <= '0;
      rem_q <= '0;
      div_q <= (freq_i == '0) ? 32'd1 : freq_i;
    end else if (busy_q) begin
      num_q <= {num_q[DivW-2:0], 1'b0};
      rem_q <= take ? (trial - {1'b0, div_q}) : trial;
      quo_q <= {quo_q[DivW-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quot_o = (|quo_q[DivW-1:32]) ? ElapsedMax : quo_q[31:0];

endmodule

// ----- rtl/kst_checker.sv -----
// ----------------------------------------------------------------------------
// kst_checker
// Port-level checks for the keyed stopwatch table.
// ----------------------------------------------------------------------------
module kst_checker
  import kst_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [31:0] elapsed_ms_o
);

  // One item in flight: no accept while a result waits.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");

  // Accept leads to a busy block next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("accept not held");

  // Not found reports the saturation value.
  a_nf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_NOTFOUND) |-> elapsed_ms_o == ElapsedMax)
    else $error("not found value");

  // Stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(elapsed_ms_o)))
    else $error("result dropped");

endmodule

bind keyed_stopwatch_table kst_checker u_kst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .elapsed_ms_o(elapsed_ms_o)
);
